FILE: rtl/core/npc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette color unit.
// ----------------------------------------------------------------------------
package npc_pkg;

  // Palette storage depth and the largest number of entries a search covers.
  localparam int PALETTE_DEPTH = 256;
  localparam int INDEX_LIMIT   = 256;
  localparam int SEARCH_MAX    = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;

  // Widths.
  localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
  localparam int CNT_W   = $clog2(SEARCH_MAX + 1);
  localparam int CFG_W   = 9;
  localparam int CH_W    = 8;
  localparam int COLOR_W = 3 * CH_W;
  localparam int IDX_W   = 8;
  localparam int SQ_W    = 2 * CH_W;
  localparam int DIST_W  = 18;

  // Largest possible squared distance: three channels of 255 squared.
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  // Item kinds carried in the input tuser bit.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

endpackage

FILE: rtl/core/nearest_palette_color_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_unit
// Maps RGB pixels to the index of the nearest entry of a stored palette.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries load and map items, told apart by tuser. A load
// item writes its color into the palette slot named by entry_index and gives
// no result. A map item searches entries 0 .. palette_count-1 and gives one
// result item: the index of the first entry with the smallest squared RGB
// distance. palette_count is to be set through the cfg channel while the
// block is idle, which the block itself does not enforce; it resets to 1.
// Operation: a load item is written to the palette as it is accepted. A map
// item scans entries 0 .. n-1, where n is the number of entries searched
// (at most 256), and no new item is accepted until its result has moved
// into the result register: the palette memory has a single read port and
// one entry is read and compared per cycle, followed by the square and the
// compare stages and the result transfer.
// The result register parts the two sides: a new item is accepted while an
// earlier result still waits. When the receiver stalls with a result held,
// a finished search waits in place until the register frees up.
// Reset clears the control state only; palette contents are undefined until
// loaded, and a search must not cover slots that were never loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color_unit
  import npc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // palette_index[7:0], min_sq_distance[25:8], zeros above
  // Configuration write channel (palette_count)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Input field unpacking.
  logic [IDX_W-1:0] in_index;
  logic [CH_W-1:0]  in_red, in_green, in_blue;
  logic             in_accept;

  assign in_index  = s_axis_tdata[7:0];
  assign in_red    = s_axis_tdata[15:8];
  assign in_green  = s_axis_tdata[23:16];
  assign in_blue   = s_axis_tdata[31:24];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  count_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CH_W-1:0]   px_r_q, px_g_q, px_b_q;

  // Read stage and square stage control.
  logic              v1_q, v1_d, last1_q;
  logic [CNT_W-1:0]  idx1_q;
  logic              v2_q, last2_q;
  logic [CNT_W-1:0]  idx2_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;

  // Running best.
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;

  // Result register.
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_load;

  // Palette memory.
  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_data_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Number of entries searched: a count of zero means one, capped at the limit.
  always_comb begin
    if (count_q == '0) begin
      n_d = CNT_W'(1);
    end else if (32'(count_q) > SEARCH_MAX) begin
      n_d = CNT_W'(SEARCH_MAX);
    end else begin
      n_d = CNT_W'(count_q);
    end
  end

  // Load items write the memory; slots beyond the depth are dropped.
  assign mem_we    = in_accept && (s_axis_tuser[0] == REQ_LOAD)
                     && (32'(in_index) < PALETTE_DEPTH);
  assign mem_waddr = ADDR_W'(in_index);
  assign mem_raddr = ADDR_W'(rd_idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= {in_red, in_green, in_blue};
    end
    rd_data_q <= palette_mem[mem_raddr];
  end

  // Pixel and search length capture on a map item.
  always_ff @(posedge clk_i) begin
    if (in_accept && (s_axis_tuser[0] == REQ_MAP)) begin
      px_r_q <= in_red;
      px_g_q <= in_green;
      px_b_q <= in_blue;
      n_q    <= n_d;
    end
  end

  // Absolute channel difference.
  function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Square stage: three narrow squares of the read entry against the pixel.
  logic [CH_W-1:0] dr, dg, db;
  assign dr = abs_diff(px_r_q, rd_data_q[23:16]);
  assign dg = abs_diff(px_g_q, rd_data_q[15:8]);
  assign db = abs_diff(px_b_q, rd_data_q[7:0]);

  always_ff @(posedge clk_i) begin
    sq_r_q  <= dr * dr;
    sq_g_q  <= dg * dg;
    sq_b_q  <= db * db;
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
  end

  // Sum and strict compare against the running best.
  logic [DIST_W-1:0] sum_dist;
  assign sum_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (in_accept && (s_axis_tuser[0] == REQ_MAP)) begin
      best_dist_d = '1;
      best_idx_d  = '0;
    end else if (v2_q && (sum_dist < best_dist_q)) begin
      best_dist_d = sum_dist;
      best_idx_d  = IDX_W'(idx2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
  end

  // Sequencer: next state, read issue and result transfer.
  always_comb begin
    state_d       = state_q;
    rd_idx_d      = rd_idx_q;
    v1_d          = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_idx_d      = '0;
        if (s_axis_tvalid && (s_axis_tuser[0] == REQ_MAP)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q < n_q) begin
          v1_d     = 1'b1;
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (v2_q && last2_q) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      v1_q     <= v1_d;
      v2_q     <= v1_q;
    end
  end

  // Tag of the entry being read, valid alongside the memory output.
  always_ff @(posedge clk_i) begin
    idx1_q  <= rd_idx_q;
    last1_q <= (rd_idx_q == n_q - CNT_W'(1));
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= best_idx_q;
      out_dist_q <= best_dist_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_dist_q, out_idx_q};

  // Compare results only arrive during a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni) v2_q |-> state_q == ST_SCAN)
    else $error("compare stage active outside a search");

  // The read index never runs past the search length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> rd_idx_q <= n_q)
    else $error("read index beyond search length");

  // A delivered distance is always a reachable squared distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_dist_q <= DIST_MAX)
    else $error("result distance out of range");

endmodule
